// ----- src/hra_pkg.sv -----
// ----------------------------------------------------------------------------
// hra_pkg
// Shared constants, types and arithmetic helpers of the HSV region adjuster.
// ----------------------------------------------------------------------------
package hra_pkg;

    localparam int unsigned MAX_SIDE_DEF = 4096;

    // Q16 levels: 65536 is 1.0, so a level needs 17 bits
    localparam int unsigned LVL_W = 17;
    localparam logic [LVL_W-1:0] ONE = 17'h10000;

    // fraction divider: floor(num * 2^16 / den), num <= den
    localparam int unsigned DIV_W      = 11;
    localparam int unsigned DIV_STAGES = 8;
    localparam int unsigned QUO_W      = 3 + 2 * (DIV_STAGES - 1);

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEFT   = 3'd0,
        REG_TOP    = 3'd1,
        REG_RIGHT  = 3'd2,
        REG_BOTTOM = 3'd3,
        REG_HUE    = 3'd4,
        REG_SAT    = 3'd5,
        REG_VAL    = 3'd6,
        REG_MIX    = 3'd7
    } cfg_reg_t;

    // pixel data riding alongside the arithmetic
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       in_rect;
        logic       span_zero;
        logic       max_zero;
    } side_t;

    // one restoring step: {quotient bit, new remainder}
    function automatic logic [DIV_W:0] div_step(input logic [DIV_W-1:0] rem,
                                                input logic [DIV_W-1:0] den);
        logic [DIV_W:0] r2;
        logic [DIV_W:0] diff;
        r2   = {rem, 1'b0};
        diff = r2 - {1'b0, den};
        if (r2 >= {1'b0, den})
            return {1'b1, diff[DIV_W-1:0]};
        else
            return {1'b0, r2[DIV_W-1:0]};
    endfunction

    // Q16 level times Q2.14 scale, clamped to 1.0
    function automatic logic [LVL_W-1:0] scale_q14(input logic [LVL_W-1:0] x,
                                                   input logic [15:0] s);
        logic [32:0] p;
        p = 33'(x) * 33'(s);
        if (p[32:14] > 19'(ONE))
            return ONE;
        else
            return p[30:14];
    endfunction

    // signed level to [0, 1.0]
    function automatic logic [LVL_W-1:0] clamp_one(input logic signed [18:0] v);
        if (v < 0)
            return '0;
        else if (v > 19'sd65536)
            return ONE;
        else
            return v[LVL_W-1:0];
    endfunction

endpackage

// ----- src/hra_ifs.sv -----
// ----------------------------------------------------------------------------
// hra_ifs
// Pixel, result and configuration channels of the HSV region adjuster.
// ----------------------------------------------------------------------------
interface hra_pix_if;
    logic        valid;
    logic        ready;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;

    modport source (output valid, pixel_x, pixel_y, red_in, green_in, blue_in,
                    input ready);
    modport sink   (input valid, pixel_x, pixel_y, red_in, green_in, blue_in,
                    output ready);
endinterface

interface hra_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       in_region;

    modport source (output valid, red_out, green_out, blue_out, in_region,
                    input ready);
    modport sink   (input valid, red_out, green_out, blue_out, in_region,
                    output ready);
endinterface

interface hra_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [hra_pkg::CFG_IDX_W-1:0]    index;
    logic [hra_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/hra_div.sv -----
// ----------------------------------------------------------------------------
// hra_div
// Pipelined fraction divider, two quotient bits per stage.
// ----------------------------------------------------------------------------
module hra_div (
    input  logic                                clk,
    input  logic [hra_pkg::DIV_STAGES-1:0]      en,
    input  logic [hra_pkg::DIV_W-1:0]           num,
    input  logic [hra_pkg::DIV_W-1:0]           den,
    output logic [hra_pkg::QUO_W-1:0]           quo
);

    localparam int unsigned NS = hra_pkg::DIV_STAGES;
    localparam int unsigned DW = hra_pkg::DIV_W;
    localparam int unsigned QW = hra_pkg::QUO_W;

    logic [DW-1:0] rem_reg [NS];
    logic [DW-1:0] den_reg [NS];
    logic [QW-1:0] quo_reg [NS];
    logic [DW-1:0] rem_next [NS];
    logic [DW-1:0] den_next [NS];
    logic [QW-1:0] quo_next [NS];

    always_comb
    begin
        logic          ib;
        logic [DW-1:0] r0;
        logic [DW:0]   t1;
        logic [DW:0]   t2;
        // first stage also takes the integer bit (num <= den)
        ib = (num >= den);
        r0 = ib ? DW'(num - den) : num;
        t1 = hra_pkg::div_step(r0, den);
        t2 = hra_pkg::div_step(t1[DW-1:0], den);
        rem_next[0] = t2[DW-1:0];
        den_next[0] = den;
        quo_next[0] = {(QW-3)'(0), ib, t1[DW], t2[DW]};
        for (int k = 1; k < NS; k++)
        begin
            t1 = hra_pkg::div_step(rem_reg[k-1], den_reg[k-1]);
            t2 = hra_pkg::div_step(t1[DW-1:0], den_reg[k-1]);
            rem_next[k] = t2[DW-1:0];
            den_next[k] = den_reg[k-1];
            quo_next[k] = {quo_reg[k-1][QW-3:0], t1[DW], t2[DW]};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NS; k++)
        begin
            if (en[k])
            begin
                rem_reg[k] <= rem_next[k];
                den_reg[k] <= den_next[k];
                quo_reg[k] <= quo_next[k];
            end
        end
    end

    assign quo = quo_reg[NS-1];

endmodule

// ----- src/hsv_region_adjust_top.sv -----
// ----------------------------------------------------------------------------
// hsv_region_adjust_top
// Hue/saturation/value adjust with colorize inside a rectangle, one pixel a
// clock while result is not stalled.
// ----------------------------------------------------------------------------
// Use:
//   pixel  : valid/ready word of column, row and 8-bit RGB.
//   result : valid/ready word of adjusted RGB and the in_region flag.
//   cfg    : register writes (index, data); always ready. Write only while
//            the pipeline is empty.
// Pixels outside [left,right) x [top,bottom), or at/after MAX_SIDE, leave
// with their colour untouched and in_region low.
// Pipeline: a word accepted on pixel passes 15 register stages on its way to
// result: region test and min/max, span and hue numerator,
// eight divider stages (hue and saturation quotients at two bits a stage;
// value and lightness come from a reciprocal product and ride alongside),
// scale, HSV/HSL products, channel select, crossfade and output rounding.
// One word is taken every cycle while result is not stalled; the rate is set by
// the pipeline, which has no loop between items.
// Each stage holds while the stage after it is full and stalled, so the
// pipeline keeps taking words into empty stages while a result waits; ready
// falls only once all 15 stages hold a word. Nothing is dropped or repeated.
// Reset empties the pipeline and returns the registers to their defaults
// (empty rectangle, unit scales, no tint).
// ----------------------------------------------------------------------------
module hsv_region_adjust_top #(
    parameter int unsigned MAX_SIDE = hra_pkg::MAX_SIDE_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    hra_pix_if.sink    pixel,
    hra_res_if.source  result,
    hra_cfg_if.sink    cfg
);

    localparam int unsigned NS     = hra_pkg::DIV_STAGES;
    localparam int unsigned LW     = hra_pkg::LVL_W;
    localparam int unsigned DW     = hra_pkg::DIV_W;
    localparam int unsigned ST_D0  = 2;
    localparam int unsigned ST_P0  = ST_D0 + NS;
    localparam int unsigned DEPTH  = ST_P0 + 5;
    localparam logic [16:0] SIDE_LIM = 17'(MAX_SIDE);
    localparam logic [LW-1:0] ONE  = hra_pkg::ONE;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [11:0] left_reg;
    logic [11:0] top_reg;
    logic [12:0] right_reg;
    logic [12:0] bottom_reg;
    logic [15:0] hue_turn_reg;
    logic [15:0] sat_scale_reg;
    logic [15:0] val_scale_reg;
    logic [12:0] tint_mix_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg      <= '0;
            top_reg       <= '0;
            right_reg     <= '0;
            bottom_reg    <= '0;
            hue_turn_reg  <= '0;
            sat_scale_reg <= 16'd16384;
            val_scale_reg <= 16'd16384;
            tint_mix_reg  <= '0;
        end
        else if (cfg.valid)
        begin
            case (hra_pkg::cfg_reg_t'(cfg.index))
                hra_pkg::REG_LEFT:   left_reg      <= cfg.data[11:0];
                hra_pkg::REG_TOP:    top_reg       <= cfg.data[11:0];
                hra_pkg::REG_RIGHT:  right_reg     <= cfg.data[12:0];
                hra_pkg::REG_BOTTOM: bottom_reg    <= cfg.data[12:0];
                hra_pkg::REG_HUE:    hue_turn_reg  <= cfg.data;
                hra_pkg::REG_SAT:    sat_scale_reg <= cfg.data;
                hra_pkg::REG_VAL:    val_scale_reg <= cfg.data;
                hra_pkg::REG_MIX:    tint_mix_reg  <= cfg.data[12:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // stage valids and hold chain
    // ------------------------------------------------------------------
    logic [DEPTH-1:0] vld_reg;
    logic [DEPTH-1:0] vld_next;
    logic [DEPTH:0]   rdy;

    always_comb
    begin
        rdy[DEPTH] = result.ready;
        for (int i = DEPTH - 1; i >= 0; i--)
            rdy[i] = ~vld_reg[i] | rdy[i+1];
        vld_next[0] = rdy[0] ? pixel.valid : vld_reg[0];
        for (int i = 1; i < DEPTH; i++)
            vld_next[i] = rdy[i] ? vld_reg[i-1] : vld_reg[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign pixel.ready  = rdy[0];
    assign result.valid = vld_reg[DEPTH-1];

    // ------------------------------------------------------------------
    // S0: region test, max/min
    // ------------------------------------------------------------------
    hra_pkg::side_t s0_side_reg;
    logic [7:0]     s0_max_reg;
    logic [7:0]     s0_min_reg;

    always_ff @(posedge clk)
    begin
        logic [7:0] mx;
        logic [7:0] mn;
        logic       ins;
        if (rdy[0])
        begin
            mx = pixel.red_in;
            mn = pixel.red_in;
            if (pixel.green_in > mx) mx = pixel.green_in;
            if (pixel.green_in < mn) mn = pixel.green_in;
            if (pixel.blue_in > mx)  mx = pixel.blue_in;
            if (pixel.blue_in < mn)  mn = pixel.blue_in;
            ins = (pixel.pixel_x >= left_reg) && ({1'b0, pixel.pixel_x} < right_reg) &&
                  (pixel.pixel_y >= top_reg) && ({1'b0, pixel.pixel_y} < bottom_reg) &&
                  ({5'b0, pixel.pixel_x} < SIDE_LIM) && ({5'b0, pixel.pixel_y} < SIDE_LIM);
            s0_side_reg.red       <= pixel.red_in;
            s0_side_reg.green     <= pixel.green_in;
            s0_side_reg.blue      <= pixel.blue_in;
            s0_side_reg.in_rect   <= ins;
            s0_side_reg.span_zero <= (mx == mn);
            s0_side_reg.max_zero  <= (mx == 8'd0);
            s0_max_reg <= mx;
            s0_min_reg <= mn;
        end
    end

    // ------------------------------------------------------------------
    // S1: span, hue numerator, value and lightness levels
    // ------------------------------------------------------------------
    hra_pkg::side_t s1_side_reg;
    logic [DW-1:0]  s1_hnum_reg;
    logic [7:0]     s1_span_reg;
    logic [7:0]     s1_max_reg;
    logic [LW-1:0]  s1_val_reg;
    logic [LW-1:0]  s1_light_reg;

    always_ff @(posedge clk)
    begin
        logic signed [12:0] sp;
        logic signed [12:0] r;
        logic signed [12:0] g;
        logic signed [12:0] b;
        logic signed [12:0] n;
        logic [8:0]         sm;
        logic [LW-1:0]      lp;
        if (rdy[1])
        begin
            r  = signed'({5'b0, s0_side_reg.red});
            g  = signed'({5'b0, s0_side_reg.green});
            b  = signed'({5'b0, s0_side_reg.blue});
            sp = signed'({5'b0, s0_max_reg - s0_min_reg});
            if (s0_max_reg == s0_side_reg.red)
                n = g - b;
            else if (s0_max_reg == s0_side_reg.green)
                n = 13'sd2 * sp + (b - r);
            else
                n = 13'sd4 * sp + (r - g);
            if (n < 0)
                n = n + 13'sd6 * sp;
            // 65536/255 = 257 + 1/255; 65536/510 = 128.5 + 1/510
            sm = {1'b0, s0_max_reg} + {1'b0, s0_min_reg};
            lp = LW'(sm) * LW'(257);
            s1_side_reg  <= s0_side_reg;
            s1_hnum_reg  <= n[DW-1:0];
            s1_span_reg  <= sp[7:0];
            s1_max_reg   <= s0_max_reg;
            s1_val_reg   <= LW'(s0_max_reg) * LW'(257) + LW'(s0_max_reg == 8'd255);
            s1_light_reg <= {1'b0, lp[LW-1:1]} +
                            LW'((sm[0] && sm >= 9'd255) || sm == 9'd510);
        end
    end

    // ------------------------------------------------------------------
    // divider lanes
    // ------------------------------------------------------------------
    logic [hra_pkg::QUO_W-1:0] q_hue;
    logic [hra_pkg::QUO_W-1:0] q_sat;
    logic [NS-1:0]             div_en;

    assign div_en = rdy[ST_D0 +: NS];

    hra_div u_div_hue (
        .clk (clk), .en (div_en),
        .num (s1_hnum_reg),
        .den (DW'(s1_span_reg) * DW'(6)),
        .quo (q_hue)
    );

    hra_div u_div_sat (
        .clk (clk), .en (div_en),
        .num (DW'(s1_span_reg)),
        .den (DW'(s1_max_reg)),
        .quo (q_sat)
    );

    hra_pkg::side_t dside_reg [NS];
    logic [LW-1:0]  dval_reg [NS];
    logic [LW-1:0]  dlight_reg [NS];

    always_ff @(posedge clk)
    begin
        if (rdy[ST_D0])
        begin
            dside_reg[0]  <= s1_side_reg;
            dval_reg[0]   <= s1_val_reg;
            dlight_reg[0] <= s1_light_reg;
        end
        for (int k = 1; k < NS; k++)
        begin
            if (rdy[ST_D0 + k])
            begin
                dside_reg[k]  <= dside_reg[k-1];
                dval_reg[k]   <= dval_reg[k-1];
                dlight_reg[k] <= dlight_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // P0: hue turn, scaling
    // ------------------------------------------------------------------
    hra_pkg::side_t p0_side_reg;
    logic [15:0]    p0_hue_reg;
    logic [LW-1:0]  p0_sat_reg;
    logic [LW-1:0]  p0_val_reg;
    logic [LW-1:0]  p0_light_reg;

    always_ff @(posedge clk)
    begin
        logic [15:0]   h;
        logic [LW-1:0] s;
        if (rdy[ST_P0])
        begin
            h = dside_reg[NS-1].span_zero ? 16'd0 : q_hue[15:0];
            s = dside_reg[NS-1].max_zero ? '0 : q_sat;
            p0_side_reg  <= dside_reg[NS-1];
            p0_hue_reg   <= h + hue_turn_reg;
            p0_sat_reg   <= hra_pkg::scale_q14(s, sat_scale_reg);
            p0_val_reg   <= hra_pkg::scale_q14(dval_reg[NS-1], val_scale_reg);
            p0_light_reg <= hra_pkg::scale_q14(dlight_reg[NS-1], val_scale_reg);
        end
    end

    // ------------------------------------------------------------------
    // P1: sector, first products, HSL chroma
    // ------------------------------------------------------------------
    hra_pkg::side_t p1_side_reg;
    logic [2:0]     p1_step_reg;
    logic [LW-1:0]  p1_pa_reg;
    logic [LW-1:0]  p1_pb_reg;
    logic [LW-1:0]  p1_dim_reg;
    logic [LW-1:0]  p1_val_reg;
    logic           p1_satz_reg;
    logic [LW-1:0]  p1_light_reg;
    logic [LW-1:0]  p1_chroma_reg;
    logic [2:0]     p1_tstep_reg;
    logic [15:0]    p1_talong_reg;

    always_ff @(posedge clk)
    begin
        logic [18:0]   h6;
        logic [18:0]   th6;
        logic [LW-1:0] om_along;
        logic [33:0]   pr_a;
        logic [33:0]   pr_b;
        logic [33:0]   pr_d;
        logic [33:0]   pr_c;
        logic [17:0]   l2;
        logic [17:0]   d;
        logic [LW-1:0] om_d;
        logic [LW-1:0] tsat;
        if (rdy[ST_P0 + 1])
        begin
            h6       = 19'(p0_hue_reg) * 19'd6;
            om_along = ONE - {1'b0, h6[15:0]};
            pr_a     = 34'(p0_sat_reg) * 34'(h6[15:0]);
            pr_b     = 34'(p0_sat_reg) * 34'(om_along);
            pr_d     = 34'(p0_val_reg) * 34'(ONE - p0_sat_reg);
            l2       = {p0_light_reg, 1'b0};
            d        = (l2 >= 18'(ONE)) ? l2 - 18'(ONE) : 18'(ONE) - l2;
            om_d     = ONE - d[LW-1:0];
            tsat     = (sat_scale_reg > 16'd16384) ? ONE : LW'(sat_scale_reg) << 2;
            pr_c     = 34'(om_d) * 34'(tsat);
            th6      = 19'(hue_turn_reg) * 19'd6;
            p1_side_reg   <= p0_side_reg;
            p1_step_reg   <= h6[18:16];
            p1_pa_reg     <= pr_a[32:16];
            p1_pb_reg     <= pr_b[32:16];
            p1_dim_reg    <= pr_d[32:16];
            p1_val_reg    <= p0_val_reg;
            p1_satz_reg   <= (p0_sat_reg == '0);
            p1_light_reg  <= p0_light_reg;
            p1_chroma_reg <= pr_c[32:16];
            p1_tstep_reg  <= th6[18:16];
            p1_talong_reg <= th6[15:0];
        end
    end

    // ------------------------------------------------------------------
    // P2: channel select for both colours
    // ------------------------------------------------------------------
    hra_pkg::side_t p2_side_reg;
    logic [LW-1:0]  p2_a_reg [3];
    logic [LW-1:0]  p2_b_reg [3];

    always_ff @(posedge clk)
    begin
        logic [33:0]        pr_f;
        logic [33:0]        pr_r;
        logic [33:0]        pr_tr;
        logic [33:0]        pr_tf;
        logic [LW-1:0]      fall;
        logic [LW-1:0]      rise;
        logic [LW-1:0]      tfall;
        logic [LW-1:0]      trise;
        logic [LW-1:0]      ch;
        logic [LW-1:0]      c [3];
        logic [LW-1:0]      t [3];
        logic signed [18:0] base;
        if (rdy[ST_P0 + 2])
        begin
            pr_f  = 34'(p1_val_reg) * 34'(ONE - p1_pa_reg);
            pr_r  = 34'(p1_val_reg) * 34'(ONE - p1_pb_reg);
            fall  = pr_f[32:16];
            rise  = pr_r[32:16];
            ch    = p1_chroma_reg;
            pr_tr = 34'(ch) * 34'(p1_talong_reg);
            pr_tf = 34'(ch) * 34'(ONE - {1'b0, p1_talong_reg});
            trise = pr_tr[32:16];
            tfall = pr_tf[32:16];
            case (p1_step_reg)
                3'd0:    begin c[0] = p1_val_reg; c[1] = rise; c[2] = p1_dim_reg; end
                3'd1:    begin c[0] = fall; c[1] = p1_val_reg; c[2] = p1_dim_reg; end
                3'd2:    begin c[0] = p1_dim_reg; c[1] = p1_val_reg; c[2] = rise; end
                3'd3:    begin c[0] = p1_dim_reg; c[1] = fall; c[2] = p1_val_reg; end
                3'd4:    begin c[0] = rise; c[1] = p1_dim_reg; c[2] = p1_val_reg; end
                default: begin c[0] = p1_val_reg; c[1] = p1_dim_reg; c[2] = fall; end
            endcase
            case (p1_tstep_reg)
                3'd0:    begin t[0] = ch; t[1] = trise; t[2] = '0; end
                3'd1:    begin t[0] = tfall; t[1] = ch; t[2] = '0; end
                3'd2:    begin t[0] = '0; t[1] = ch; t[2] = trise; end
                3'd3:    begin t[0] = '0; t[1] = tfall; t[2] = ch; end
                3'd4:    begin t[0] = trise; t[1] = '0; t[2] = ch; end
                default: begin t[0] = ch; t[1] = '0; t[2] = tfall; end
            endcase
            base = signed'(19'(p1_light_reg)) - signed'(19'(ch >> 1));
            for (int i = 0; i < 3; i++)
            begin
                p2_a_reg[i] <= p1_satz_reg ? p1_val_reg : c[i];
                if (ch == '0)
                    p2_b_reg[i] <= p1_light_reg;
                else
                    p2_b_reg[i] <= hra_pkg::clamp_one(signed'(19'(t[i])) + base);
            end
            p2_side_reg <= p1_side_reg;
        end
    end

    // ------------------------------------------------------------------
    // P3: crossfade
    // ------------------------------------------------------------------
    hra_pkg::side_t p3_side_reg;
    logic [LW-1:0]  p3_v_reg [3];

    always_ff @(posedge clk)
    begin
        logic [12:0] m;
        logic [12:0] im;
        logic [30:0] acc;
        if (rdy[ST_P0 + 3])
        begin
            m  = (tint_mix_reg > 13'd4096) ? 13'd4096 : tint_mix_reg;
            im = 13'd4096 - m;
            for (int i = 0; i < 3; i++)
            begin
                acc = 31'(p2_a_reg[i]) * 31'(im) + 31'(p2_b_reg[i]) * 31'(m);
                p3_v_reg[i] <= (tint_mix_reg != '0) ? acc[28:12] : p2_a_reg[i];
            end
            p3_side_reg <= p2_side_reg;
        end
    end

    // ------------------------------------------------------------------
    // P4: rounding to 8 bits, output word
    // ------------------------------------------------------------------
    logic [7:0] red_reg;
    logic [7:0] green_reg;
    logic [7:0] blue_reg;
    logic       region_reg;

    always_ff @(posedge clk)
    begin
        logic [24:0] rr;
        logic [24:0] gg;
        logic [24:0] bb;
        if (rdy[ST_P0 + 4])
        begin
            rr = 25'(p3_v_reg[0]) * 25'd255 + 25'd32768;
            gg = 25'(p3_v_reg[1]) * 25'd255 + 25'd32768;
            bb = 25'(p3_v_reg[2]) * 25'd255 + 25'd32768;
            red_reg    <= p3_side_reg.in_rect ? rr[23:16] : p3_side_reg.red;
            green_reg  <= p3_side_reg.in_rect ? gg[23:16] : p3_side_reg.green;
            blue_reg   <= p3_side_reg.in_rect ? bb[23:16] : p3_side_reg.blue;
            region_reg <= p3_side_reg.in_rect;
        end
    end

    assign result.red_out   = red_reg;
    assign result.green_out = green_reg;
    assign result.blue_out  = blue_reg;
    assign result.in_region = region_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    // input is refused only with every stage occupied
    a_full_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !pixel.ready |-> (&vld_reg))
        else $error("input held off with a bubble in the pipeline");

    // hue quotient stays below one turn whenever the pixel has colour
    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[ST_P0-1] && !dside_reg[NS-1].span_zero) |-> (q_hue[16] == 1'b0))
        else $error("hue quotient reached a full turn");

    // scaled levels never exceed 1.0
    a_level_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_P0] |-> (p0_sat_reg <= ONE && p0_val_reg <= ONE && p0_light_reg <= ONE))
        else $error("scaled level above 1.0");

    // a stalled output word does not change
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.ready) |=> ($stable(red_reg) && $stable(region_reg)))
        else $error("stalled result word changed");

endmodule
